>>> rtl/glsd_pkg.sv
// Shared types, widths, register indexes and the microcode program for the grid landmark detector.
// Depends on nothing; every other file in rtl refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package glsd_pkg;

    // Field widths fixed by the interface.
    localparam int POS_BITS      = 32;
    localparam int TIME_BITS     = 48;
    localparam int SPACING_BITS  = 16;
    localparam int TOL_BITS      = 16;
    localparam int DEBOUNCE_BITS = 24;
    localparam int COLS_BITS     = 16;
    localparam int ID_BITS       = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Derived datapath widths.
    localparam int REL_BITS   = POS_BITS + 1;          // pos - origin, exact
    localparam int NUM_BITS   = POS_BITS + 2;          // 2|rel| + s
    localparam int DIV_BITS   = SPACING_BITS + 1;      // 2s, and the remainder
    localparam int RESID_BITS = SPACING_BITS + 1;      // signed residual per axis
    localparam int SQ_BITS    = 2 * TOL_BITS + 1;      // squared distances
    localparam int PROD_BITS  = SQ_BITS;               // kept product bits
    localparam int MUL_A_BITS = ID_BITS + 1;
    localparam int MUL_B_BITS = RESID_BITS;
    localparam int DIV_STEPS  = NUM_BITS;              // one quotient bit per step
    localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);
    localparam int PC_BITS    = 4;

    typedef struct packed {
        logic                       paused;
        logic                       pose_valid;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]       now_us;
    } item_t;

    typedef struct packed {
        logic signed [ID_BITS-1:0] mark_id;
        logic signed [ID_BITS-1:0] index_x;
        logic signed [ID_BITS-1:0] index_y;
    } result_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_SPACING  = 3'd0,
        REG_TOLERANCE     = 3'd1,
        REG_DEBOUNCE_TIME = 3'd2,
        REG_ORIGIN_X      = 3'd3,
        REG_ORIGIN_Y      = 3'd4,
        REG_GRID_COLUMNS  = 3'd5
    } reg_index_t;

    localparam logic [SPACING_BITS-1:0]  RESET_SPACING  = 16'd819;
    localparam logic [TOL_BITS-1:0]      RESET_TOL      = 16'd51;
    localparam logic [DEBOUNCE_BITS-1:0] RESET_DEBOUNCE = 24'd5000;
    localparam logic [COLS_BITS-1:0]     RESET_COLS     = 16'd10000;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_DIV,
        OP_SQX,
        OP_SQY,
        OP_SUM,
        OP_CMP,
        OP_ID,
        OP_EMIT
    } op_t;

    // Jump condition of a control word; a true condition loads the target.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_IGNORE,
        C_DIV_MORE,
        C_FAR,
        C_SUPPRESS,
        C_OUT_BUSY
    } cond_t;

    typedef logic [PC_BITS-1:0] pc_t;

    typedef struct packed {
        logic  take_item;
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctl_t;

    typedef struct packed {
        logic item_accept;
        logic ignore;
        logic div_more;
        logic far;
        logic suppress;
        logic out_busy;
    } status_t;

    // Program addresses.
    localparam pc_t PC_WAIT  = 4'd0;
    localparam pc_t PC_CHECK = 4'd1;
    localparam pc_t PC_PREP  = 4'd2;
    localparam pc_t PC_DIV   = 4'd3;
    localparam pc_t PC_SQX   = 4'd4;
    localparam pc_t PC_SQY   = 4'd5;
    localparam pc_t PC_SUM   = 4'd6;
    localparam pc_t PC_CMP   = 4'd7;
    localparam pc_t PC_ID    = 4'd8;
    localparam pc_t PC_DEB   = 4'd9;
    localparam pc_t PC_EMIT  = 4'd10;
    localparam pc_t PC_RET   = 4'd11;

    // The microcode store: one control word per step.
    function automatic ctl_t ucode(input pc_t pc);
        ctl_t w;
        w = '{take_item: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:  w = '{take_item: 1'b1, op: OP_LOAD, cond: C_NO_ITEM,  target: PC_WAIT};
            PC_CHECK: w = '{take_item: 1'b0, op: OP_NONE, cond: C_IGNORE,   target: PC_WAIT};
            PC_PREP:  w = '{take_item: 1'b0, op: OP_PREP, cond: C_NEVER,    target: PC_WAIT};
            PC_DIV:   w = '{take_item: 1'b0, op: OP_DIV,  cond: C_DIV_MORE, target: PC_DIV};
            PC_SQX:   w = '{take_item: 1'b0, op: OP_SQX,  cond: C_NEVER,    target: PC_WAIT};
            PC_SQY:   w = '{take_item: 1'b0, op: OP_SQY,  cond: C_NEVER,    target: PC_WAIT};
            PC_SUM:   w = '{take_item: 1'b0, op: OP_SUM,  cond: C_NEVER,    target: PC_WAIT};
            PC_CMP:   w = '{take_item: 1'b0, op: OP_CMP,  cond: C_FAR,      target: PC_WAIT};
            PC_ID:    w = '{take_item: 1'b0, op: OP_ID,   cond: C_NEVER,    target: PC_WAIT};
            PC_DEB:   w = '{take_item: 1'b0, op: OP_NONE, cond: C_SUPPRESS, target: PC_WAIT};
            PC_EMIT:  w = '{take_item: 1'b0, op: OP_EMIT, cond: C_OUT_BUSY, target: PC_EMIT};
            PC_RET:   w = '{take_item: 1'b0, op: OP_NONE, cond: C_ALWAYS,   target: PC_WAIT};
            default:  w = '{take_item: 1'b0, op: OP_NONE, cond: C_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/glsd_div.sv
// One lane of the restoring divider: one quotient bit per step, quotient shifted into the dividend.
// Depends on glsd_pkg for the widths.
`timescale 1ns / 1ps
`default_nettype none

module glsd_div (
    input  wire logic                              clk,
    input  wire logic                              load,
    input  wire logic                              step,
    input  wire logic [glsd_pkg::NUM_BITS-1:0]     dividend,
    input  wire logic [glsd_pkg::DIV_BITS-1:0]     divisor,
    output logic      [glsd_pkg::NUM_BITS-1:0]     quot,
    output logic      [glsd_pkg::DIV_BITS-1:0]     rem
);

    logic [glsd_pkg::NUM_BITS-1:0] num_reg, num_next;
    logic [glsd_pkg::DIV_BITS-1:0] rem_reg, rem_next;
    logic [glsd_pkg::DIV_BITS-1:0] dsr_reg, dsr_next;
    logic [glsd_pkg::DIV_BITS:0]   shifted;
    logic [glsd_pkg::DIV_BITS:0]   trial;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[glsd_pkg::NUM_BITS-1]};
        trial    = shifted - {1'b0, dsr_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (load)
        begin
            num_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (step)
        begin
            // The remainder stays below the divisor, so a clear borrow means a quotient one.
            if (!trial[glsd_pkg::DIV_BITS])
            begin
                rem_next = trial[glsd_pkg::DIV_BITS-1:0];
                num_next = {num_reg[glsd_pkg::NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[glsd_pkg::DIV_BITS-1:0];
                num_next = {num_reg[glsd_pkg::NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/glsd_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on glsd_pkg for the control word, status group and program.
`timescale 1ns / 1ps
`default_nettype none

module glsd_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire glsd_pkg::status_t status,
    output glsd_pkg::ctl_t         ctl
);

    glsd_pkg::pc_t pc_reg, pc_next;
    logic          jump;

    always_comb
    begin
        ctl = glsd_pkg::ucode(pc_reg);
    end

    always_comb
    begin
        unique case (ctl.cond)
            glsd_pkg::C_NEVER:    jump = 1'b0;
            glsd_pkg::C_ALWAYS:   jump = 1'b1;
            glsd_pkg::C_NO_ITEM:  jump = !status.item_accept;
            glsd_pkg::C_IGNORE:   jump = status.ignore;
            glsd_pkg::C_DIV_MORE: jump = status.div_more;
            glsd_pkg::C_FAR:      jump = status.far;
            glsd_pkg::C_SUPPRESS: jump = status.suppress;
            glsd_pkg::C_OUT_BUSY: jump = status.out_busy;
            default:              jump = 1'b1;
        endcase
        pc_next = jump ? ctl.target : pc_reg + glsd_pkg::pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= glsd_pkg::PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/grid_landmark_detector_top.sv
// Grid landmark detector: snaps positions to a grid, tests the residual radius and debounces ids.
// An accepted word's result is offered once the output register is free; the division is bit-serial,
// both axes in parallel lanes. A new input word is taken only once the previous one is emitted or
// dropped as paused, invalid, far from a mark or debounced.
// Reset (rst_n, asynchronous, active low) restores the register defaults, clears the over-mark
// flag, sets the last id to all ones and the last emit time to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module grid_landmark_detector_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input words.
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire glsd_pkg::item_t                      item,
    // Result words.
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output glsd_pkg::result_t                         result,
    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [glsd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [glsd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    // Configuration registers.
    logic [glsd_pkg::SPACING_BITS-1:0]  spacing_reg;
    logic [glsd_pkg::TOL_BITS-1:0]      tol_reg;
    logic [glsd_pkg::DEBOUNCE_BITS-1:0] debounce_reg;
    logic signed [glsd_pkg::POS_BITS-1:0] origin_x_reg;
    logic signed [glsd_pkg::POS_BITS-1:0] origin_y_reg;
    logic [glsd_pkg::COLS_BITS-1:0]     cols_reg;

    // Detector state.
    logic                               over_mark_reg, over_mark_next;
    logic [glsd_pkg::ID_BITS-1:0]       last_id_reg, last_id_next;
    logic [glsd_pkg::TIME_BITS-1:0]     last_time_reg, last_time_next;
    logic                               out_valid_reg, out_valid_next;
    logic [glsd_pkg::STEP_BITS-1:0]     cnt_reg, cnt_next;

    // Working registers for the word in flight.
    logic                               ignore_reg, ignore_next;
    logic signed [glsd_pkg::REL_BITS-1:0] rel_x_reg, rel_x_next;
    logic signed [glsd_pkg::REL_BITS-1:0] rel_y_reg, rel_y_next;
    logic [glsd_pkg::TIME_BITS-1:0]     now_reg, now_next;
    logic [glsd_pkg::SPACING_BITS-1:0]  s_reg, s_next;
    logic [glsd_pkg::ID_BITS-1:0]       ix_reg, ix_next;
    logic [glsd_pkg::ID_BITS-1:0]       iy_reg, iy_next;
    logic [glsd_pkg::SQ_BITS-1:0]       acc_reg, acc_next;
    logic [glsd_pkg::PROD_BITS-1:0]     prod_reg, prod_next;
    logic [glsd_pkg::ID_BITS-1:0]       id_reg, id_next;
    glsd_pkg::result_t                  result_reg, result_next;

    // Sequencer handshake.
    glsd_pkg::ctl_t                     ctl;
    glsd_pkg::status_t                  status;
    logic                               item_accept;
    logic                               emit;

    // Divider lanes.
    logic                               div_load, div_step;
    logic [glsd_pkg::SPACING_BITS-1:0]  s_eff;
    logic [glsd_pkg::NUM_BITS-1:0]      rel2_x, rel2_y, s_wide;
    logic [glsd_pkg::NUM_BITS-1:0]      dividend_x, dividend_y;
    logic [glsd_pkg::DIV_BITS-1:0]      divisor;
    logic [glsd_pkg::NUM_BITS-1:0]      quot_x, quot_y;
    logic [glsd_pkg::DIV_BITS-1:0]      rem_x, rem_y;

    // Residuals, the shared multiplier and the debounce test.
    logic [glsd_pkg::DIV_BITS:0]        diff_x, diff_y;
    logic signed [glsd_pkg::RESID_BITS-1:0] dx, dy;
    logic signed [glsd_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [glsd_pkg::MUL_B_BITS-1:0] mul_b;
    logic signed [glsd_pkg::MUL_A_BITS+glsd_pkg::MUL_B_BITS-1:0] mul_p;
    logic [glsd_pkg::TIME_BITS:0]       elapsed;
    logic                               too_soon;

    assign cfg_ready    = 1'b1;
    assign item_ready   = ctl.take_item;
    assign item_accept  = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // Configuration registers take a write in any cycle; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg  <= glsd_pkg::RESET_SPACING;
            tol_reg      <= glsd_pkg::RESET_TOL;
            debounce_reg <= glsd_pkg::RESET_DEBOUNCE;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            cols_reg     <= glsd_pkg::RESET_COLS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (glsd_pkg::reg_index_t'(cfg_index))
                glsd_pkg::REG_GRID_SPACING:
                    spacing_reg <= cfg_data[glsd_pkg::SPACING_BITS-1:0];
                glsd_pkg::REG_TOLERANCE:
                    tol_reg <= cfg_data[glsd_pkg::TOL_BITS-1:0];
                glsd_pkg::REG_DEBOUNCE_TIME:
                    debounce_reg <= cfg_data[glsd_pkg::DEBOUNCE_BITS-1:0];
                glsd_pkg::REG_ORIGIN_X:
                    origin_x_reg <= cfg_data[glsd_pkg::POS_BITS-1:0];
                glsd_pkg::REG_ORIGIN_Y:
                    origin_y_reg <= cfg_data[glsd_pkg::POS_BITS-1:0];
                glsd_pkg::REG_GRID_COLUMNS:
                    cols_reg <= cfg_data[glsd_pkg::COLS_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    glsd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    // A spacing of zero behaves as a spacing of one. The dividend is 2|rel| + s, formed
    // directly from the sign so that only one adder sits in the path.
    always_comb
    begin
        s_eff      = (spacing_reg == '0) ? glsd_pkg::SPACING_BITS'(1) : spacing_reg;
        s_wide     = glsd_pkg::NUM_BITS'(s_eff);
        rel2_x     = {rel_x_reg, 1'b0};
        rel2_y     = {rel_y_reg, 1'b0};
        dividend_x = rel_x_reg[glsd_pkg::REL_BITS-1] ? s_wide - rel2_x : s_wide + rel2_x;
        dividend_y = rel_y_reg[glsd_pkg::REL_BITS-1] ? s_wide - rel2_y : s_wide + rel2_y;
        divisor    = {s_eff, 1'b0};
        div_load   = (ctl.op == glsd_pkg::OP_PREP);
        div_step   = (ctl.op == glsd_pkg::OP_DIV);
    end

    glsd_div u_div_x (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (dividend_x),
        .divisor  (divisor),
        .quot     (quot_x),
        .rem      (rem_x)
    );

    glsd_div u_div_y (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (dividend_y),
        .divisor  (divisor),
        .quot     (quot_y),
        .rem      (rem_y)
    );

    // With r the remainder of (2|rel| + s) / 2s, the residual magnitude is (r - s) / 2, and r - s
    // is always even. The residual's sign does not matter since it is only squared.
    always_comb
    begin
        diff_x = {1'b0, rem_x} - (glsd_pkg::DIV_BITS + 1)'(s_reg);
        diff_y = {1'b0, rem_y} - (glsd_pkg::DIV_BITS + 1)'(s_reg);
        dx     = diff_x[glsd_pkg::DIV_BITS:1];
        dy     = diff_y[glsd_pkg::DIV_BITS:1];
    end

    // One shared multiplier: both squares, the squared tolerance, then row times columns.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.op)
            glsd_pkg::OP_SQX:
            begin
                mul_a = glsd_pkg::MUL_A_BITS'(dx);
                mul_b = dx;
            end
            glsd_pkg::OP_SQY:
            begin
                mul_a = glsd_pkg::MUL_A_BITS'(dy);
                mul_b = dy;
            end
            glsd_pkg::OP_SUM:
            begin
                mul_a = glsd_pkg::MUL_A_BITS'(tol_reg);
                mul_b = glsd_pkg::MUL_B_BITS'(tol_reg);
            end
            glsd_pkg::OP_CMP:
            begin
                mul_a = glsd_pkg::MUL_A_BITS'(iy_reg);
                mul_b = glsd_pkg::MUL_B_BITS'(cols_reg);
            end
            default:
            begin
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Time running backwards counts as no time elapsed.
    always_comb
    begin
        elapsed = {1'b0, now_reg} - {1'b0, last_time_reg};
        if (elapsed[glsd_pkg::TIME_BITS])
        begin
            too_soon = (debounce_reg != '0);
        end
        else
        begin
            too_soon = elapsed[glsd_pkg::TIME_BITS-1:0] < glsd_pkg::TIME_BITS'(debounce_reg);
        end
    end

    always_comb
    begin
        status.item_accept = item_accept;
        status.ignore      = ignore_reg;
        status.div_more    = (cnt_reg != glsd_pkg::STEP_BITS'(1));
        status.far         = (acc_reg > prod_reg);
        status.suppress    = over_mark_reg && (id_reg == last_id_reg) && too_soon;
        status.out_busy    = out_valid_reg && !result_ready;
        emit               = (ctl.op == glsd_pkg::OP_EMIT) && !status.out_busy;
    end

    // Datapath next values, steered by the current control word.
    always_comb
    begin
        over_mark_next = over_mark_reg;
        last_id_next   = last_id_reg;
        last_time_next = last_time_reg;
        cnt_next       = cnt_reg;
        ignore_next    = ignore_reg;
        rel_x_next     = rel_x_reg;
        rel_y_next     = rel_y_reg;
        now_next       = now_reg;
        s_next         = s_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        acc_next       = acc_reg;
        prod_next      = mul_p[glsd_pkg::PROD_BITS-1:0];
        id_next        = id_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !result_ready;

        case (ctl.op)
            glsd_pkg::OP_LOAD:
            begin
                if (item_accept)
                begin
                    ignore_next = item.paused || !item.pose_valid;
                    rel_x_next  = {item.pos_x[glsd_pkg::POS_BITS-1], item.pos_x}
                                - {origin_x_reg[glsd_pkg::POS_BITS-1], origin_x_reg};
                    rel_y_next  = {item.pos_y[glsd_pkg::POS_BITS-1], item.pos_y}
                                - {origin_y_reg[glsd_pkg::POS_BITS-1], origin_y_reg};
                    now_next    = item.now_us;
                end
            end
            glsd_pkg::OP_PREP:
            begin
                s_next   = s_eff;
                cnt_next = glsd_pkg::STEP_BITS'(glsd_pkg::DIV_STEPS);
            end
            glsd_pkg::OP_DIV:
            begin
                cnt_next = cnt_reg - glsd_pkg::STEP_BITS'(1);
            end
            glsd_pkg::OP_SQX:
            begin
                // Indices wrap to the id width; the residual already used the exact quotient.
                ix_next = rel_x_reg[glsd_pkg::REL_BITS-1]
                        ? -quot_x[glsd_pkg::ID_BITS-1:0] : quot_x[glsd_pkg::ID_BITS-1:0];
                iy_next = rel_y_reg[glsd_pkg::REL_BITS-1]
                        ? -quot_y[glsd_pkg::ID_BITS-1:0] : quot_y[glsd_pkg::ID_BITS-1:0];
            end
            glsd_pkg::OP_SQY:
            begin
                acc_next = prod_reg;
            end
            glsd_pkg::OP_SUM:
            begin
                acc_next = acc_reg + prod_reg;
            end
            glsd_pkg::OP_CMP:
            begin
                if (status.far)
                begin
                    over_mark_next = 1'b0;
                end
            end
            glsd_pkg::OP_ID:
            begin
                id_next = prod_reg[glsd_pkg::ID_BITS-1:0] + ix_reg;
            end
            glsd_pkg::OP_EMIT:
            begin
                if (emit)
                begin
                    result_next.mark_id = id_reg;
                    result_next.index_x = ix_reg;
                    result_next.index_y = iy_reg;
                    out_valid_next      = 1'b1;
                    last_id_next        = id_reg;
                    last_time_next      = now_reg;
                    over_mark_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_mark_reg <= 1'b0;
            last_id_reg   <= '1;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ignore_reg    <= 1'b1;
        end
        else
        begin
            over_mark_reg <= over_mark_next;
            last_id_reg   <= last_id_next;
            last_time_reg <= last_time_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            ignore_reg    <= ignore_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        rel_x_reg  <= rel_x_next;
        rel_y_reg  <= rel_y_next;
        now_reg    <= now_next;
        s_reg      <= s_next;
        ix_reg     <= ix_next;
        iy_reg     <= iy_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        id_reg     <= id_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire
